[rtl/core/bma_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bma_pkg
// Shared constants and types for the boxcar moving average.
// ----------------------------------------------------------------------------
package bma_pkg;

    localparam int MAX_WINDOW = 32;
    localparam int SAMPLE_W   = 16;
    localparam int WIN_CFG_W  = 6;

    localparam logic [WIN_CFG_W-1:0] WINDOW_RESET = WIN_CFG_W'(20);

    // History pointer, effective window length, running sum and its magnitude.
    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int NW    = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW) + 1;
    localparam int MAG_W = SUM_W - 1;
    localparam int REM_W = NW + 1;
    localparam int CNT_W = $clog2(MAG_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

[rtl/core/bma_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bma_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[rtl/core/boxcar_moving_average.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// boxcar_moving_average
// Mean of the last N signed samples, using a circular history buffer, a
// running sum and a bit-serial restoring divider.
// ----------------------------------------------------------------------------
// An accepted sample passes S_SUM, the bit-serial divide in S_DIV and S_DONE,
// which loads the registered result; o_stall holds off new samples till then.
// The divider takes one quotient bit per cycle over the 21-bit sum magnitude.
// Reset (synchronous, active low) sets the window to 20 and clears the history
// valid bits and running sum; a window write clears them the same way.
// ----------------------------------------------------------------------------
module boxcar_moving_average (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [bma_pkg::WIN_CFG_W-1:0]   i_window_length,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic signed [bma_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic signed [bma_pkg::SAMPLE_W-1:0]  o_average
);
    import bma_pkg::*;

    t_state                     r_state,    n_state;
    logic [NW-1:0]              r_win_n,    n_win_n;
    logic [PTR_W-1:0]           r_ptr,      n_ptr;
    logic [MAX_WINDOW-1:0]      r_hist_vld, n_hist_vld;
    logic signed [SUM_W-1:0]    r_sum,      n_sum;
    logic signed [SAMPLE_W-1:0] r_sample,   n_sample;
    logic [MAG_W-1:0]           r_mag,      n_mag;
    logic [NW-1:0]              r_rem,      n_rem;
    logic                       r_neg,      n_neg;
    logic [CNT_W-1:0]           r_cnt,      n_cnt;
    logic                       r_out_vld,  n_out_vld;
    logic signed [SAMPLE_W-1:0] r_avg,      n_avg;

    logic                       accept;
    logic                       ram_we;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic signed [SAMPLE_W-1:0] leaving;
    logic signed [SUM_W-1:0]    sum_new;
    logic [REM_W-1:0]           rem_sh;
    logic [MAG_W-1:0]           mag_neg;
    logic [NW-1:0]              cfg_win;

    bma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ptr),
        .i_wdata (r_sample),
        .i_re    (accept),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    assign o_stall   = (r_state != S_IDLE);
    assign accept    = i_valid && !o_stall;
    assign o_valid   = r_out_vld;
    assign o_average = r_avg;

    always_comb begin
        if (i_window_length == '0) begin
            cfg_win = NW'(1);
        end else if (int'(i_window_length) > MAX_WINDOW) begin
            cfg_win = NW'(MAX_WINDOW);
        end else begin
            cfg_win = NW'(i_window_length);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_win_n    = r_win_n;
        n_ptr      = r_ptr;
        n_hist_vld = r_hist_vld;
        n_sum      = r_sum;
        n_sample   = r_sample;
        n_mag      = r_mag;
        n_rem      = r_rem;
        n_neg      = r_neg;
        n_cnt      = r_cnt;
        n_out_vld  = r_out_vld;
        n_avg      = r_avg;
        ram_we     = 1'b0;

        // A slot that was never written since the last clear holds a zero sample.
        leaving = r_hist_vld[r_ptr] ? signed'(ram_rdata) : '0;
        sum_new = r_sum + SUM_W'(r_sample) - SUM_W'(leaving);
        rem_sh  = {r_rem, r_mag[MAG_W-1]};
        mag_neg = ~r_mag + MAG_W'(1);

        if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_sample = i_sample;
                    n_state  = S_SUM;
                end
            end
            S_SUM: begin
                ram_we            = 1'b1;
                n_hist_vld[r_ptr] = 1'b1;
                n_sum             = sum_new;
                n_neg             = sum_new[SUM_W-1];
                n_mag             = sum_new[SUM_W-1] ? MAG_W'(-sum_new) : MAG_W'(sum_new);
                n_rem             = '0;
                n_cnt             = CNT_W'(MAG_W - 1);
                if (NW'(r_ptr) + NW'(1) == r_win_n) begin
                    n_ptr = '0;
                end else begin
                    n_ptr = r_ptr + PTR_W'(1);
                end
                n_state = S_DIV;
            end
            S_DIV: begin
                // Restoring division: quotient bits shift in where dividend bits leave.
                if (rem_sh >= REM_W'(r_win_n)) begin
                    n_rem = NW'(rem_sh - REM_W'(r_win_n));
                    n_mag = {r_mag[MAG_W-2:0], 1'b1};
                end else begin
                    n_rem = NW'(rem_sh);
                    n_mag = {r_mag[MAG_W-2:0], 1'b0};
                end
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || !i_stall) begin
                    n_out_vld = 1'b1;
                    n_avg     = r_neg ? signed'(mag_neg[SAMPLE_W-1:0])
                                      : signed'(r_mag[SAMPLE_W-1:0]);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_win_n    = cfg_win;
            n_ptr      = '0;
            n_hist_vld = '0;
            n_sum      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_win_n    <= NW'(WINDOW_RESET);
            r_ptr      <= '0;
            r_hist_vld <= '0;
            r_sum      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_win_n    <= n_win_n;
            r_ptr      <= n_ptr;
            r_hist_vld <= n_hist_vld;
            r_sum      <= n_sum;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_mag    <= n_mag;
        r_rem    <= n_rem;
        r_neg    <= n_neg;
        r_cnt    <= n_cnt;
        r_avg    <= n_avg;
    end

`ifndef SYNTHESIS
    a_ptr_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        NW'(r_ptr) < r_win_n)
        else $error("history pointer outside the window");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && (r_cnt == '0) |=> r_rem < r_win_n)
        else $error("division remainder not below window length");

    a_quotient_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> r_mag <= MAG_W'(32768))
        else $error("average magnitude exceeds sample range");

    a_result_from_divider: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_DONE)
        else $error("result beat without a finished division");
`endif

endmodule
`default_nettype wire
